// ----- rtl/idalloc_pkg.sv -----
// idalloc_pkg: shared types and codes for the identifier allocator
`default_nettype none

package idalloc_pkg;

	localparam int FIELD_W = 16;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_IGNORED   = 2'd1;
	localparam logic [1:0] STATUS_DROPPED   = 2'd2;
	localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] given_id;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/id_allocator_with_free_queue.sv -----
// id_allocator_with_free_queue: unique nonzero identifier allocator, top level
// request in the input stage, response in the result stage; throughput: one command
// per cycle unless a response waits; the free queue head is prefetched from the ram
// so the allocate decision, queue update and counter update all fit in one stage
// reset: queue empty, fresh counter at 1, both stages empty; queue ram is not cleared
`default_nettype none

module id_allocator_with_free_queue #(
	parameter int ID_WIDTH    = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire idalloc_pkg::req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output idalloc_pkg::rsp_t      rsp
);

	import idalloc_pkg::*;

	logic                valid_s1;
	req_t                req_s1;
	logic                valid_s2;
	rsp_t                rsp_s2;
	logic [ID_WIDTH:0]   next_fresh_q;

	logic                go;
	logic                is_alloc;
	logic [ID_WIDTH-1:0] rid;
	logic [ID_WIDTH-1:0] head_id;
	logic [ID_WIDTH-1:0] popped;
	logic [ID_WIDTH-1:0] id;
	logic                need_fresh;
	logic                exhausted;
	logic                ignore_rel;
	logic                take_fresh;
	logic [1:0]          status;
	logic [FIELD_W-1:0]  given;
	queue_ctrl_t         qctrl;
	queue_stat_t         qstat;

	assign go        = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || go;
	assign is_alloc  = (req_s1.cmd == CMD_ALLOC);

	// release id resized to the identifier width
	for (genvar i = 0; i < ID_WIDTH; i++) begin : g_rid
		if (i < FIELD_W) begin : g_bit
			assign rid[i] = req_s1.release_id[i];
		end else begin : g_zero
			assign rid[i] = 1'b0;
		end
	end

	assign popped     = qstat.nonempty ? head_id : '0;
	assign need_fresh = (popped == '0);
	assign exhausted  = next_fresh_q[ID_WIDTH];
	assign ignore_rel = ({1'b0, rid} >= next_fresh_q);
	assign take_fresh = is_alloc && need_fresh && !exhausted;

	always_comb begin
		id     = '0;
		status = STATUS_OK;
		if (is_alloc) begin
			if (!need_fresh) begin
				id = popped;
			end else if (exhausted) begin
				status = STATUS_EXHAUSTED;
			end else begin
				id = next_fresh_q[ID_WIDTH-1:0];
			end
		end else if (ignore_rel) begin
			status = STATUS_IGNORED;
		end else if (qstat.full) begin
			status = STATUS_DROPPED;
		end
	end

	for (genvar j = 0; j < FIELD_W; j++) begin : g_given
		if (j < ID_WIDTH) begin : g_bit
			assign given[j] = id[j];
		end else begin : g_zero
			assign given[j] = 1'b0;
		end
	end

	assign qctrl.pop  = go && is_alloc && qstat.nonempty;
	assign qctrl.push = go && !is_alloc && !ignore_rel && !qstat.full;

	idalloc_free_queue #(
		.ID_WIDTH   (ID_WIDTH),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_free_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.push_id(rid),
		.stat   (qstat),
		.head_id(head_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			next_fresh_q <= (ID_WIDTH + 1)'(1);
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (go) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
			if (go && take_fresh) begin
				next_fresh_q <= next_fresh_q + (ID_WIDTH + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (go) begin
			rsp_s2.given_id <= given;
			rsp_s2.status   <= status;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

// ----- rtl/idalloc_ram.sv -----
// idalloc_ram: generic single write port, single registered read port ram
`default_nettype none

module idalloc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/idalloc_free_queue.sv -----
// idalloc_free_queue: fifo of released identifiers with head prefetch
`default_nettype none

module idalloc_free_queue #(
	parameter int ID_WIDTH    = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire idalloc_pkg::queue_ctrl_t  ctrl,
	input  wire logic [ID_WIDTH-1:0]       push_id,
	output idalloc_pkg::queue_stat_t       stat,
	output logic      [ID_WIDTH-1:0]       head_id
);

	import idalloc_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_d;
	logic [AW-1:0]       tail_d;
	logic [ID_WIDTH-1:0] ram_rdata;
	logic                byp_q;
	logic [ID_WIDTH-1:0] byp_data_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (ctrl.pop) begin
			head_d = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
		end
		if (ctrl.push) begin
			tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CW'(1);
			end
			byp_q <= ctrl.push && (tail_q == head_d);
		end
	end

	// capture push data to bypass a write into the slot being prefetched
	always_ff @(posedge clk) begin
		byp_data_q <= push_id;
	end

	idalloc_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.push),
		.waddr(tail_q),
		.wdata(push_id),
		.raddr(head_d),
		.rdata(ram_rdata)
	);

	assign head_id       = byp_q ? byp_data_q : ram_rdata;
	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == FULL_CNT);

endmodule

`default_nettype wire

// ----- rtl/idalloc_checker.sv -----
// idalloc_checker: port level assertions for the identifier allocator, with bind
`default_nettype none

module idalloc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire idalloc_pkg::req_t req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire idalloc_pkg::rsp_t rsp
);

	import idalloc_pkg::*;

	// exhausted allocate hands out nothing
	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_EXHAUSTED |-> rsp.given_id == '0)
		else $error("exhausted response carries an identifier");

	// a failed release hands out nothing
	a_release_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_IGNORED || rsp.status == STATUS_DROPPED)
		|-> rsp.given_id == '0)
		else $error("failed release carries an identifier");

	// requests back up only behind a waiting response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled with no response pending");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed before transfer");

endmodule

bind id_allocator_with_free_queue idalloc_checker u_idalloc_checker (.*);

`default_nettype wire
